>>> src/mpf_pkg.sv
`timescale 1ns / 1ps

package mpf_pkg;

  localparam int MPF_CMD_DEPTH = 2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  localparam logic [2:0] POS_CHAR_FIRST = 3'd0;
  localparam logic [2:0] POS_HEX_FIRST  = 3'd3;
  localparam logic [2:0] POS_DEC_FIRST  = 3'd4;

  // k times ten to the power of the digit position
  localparam logic [16:0] DEC_TBL [5][10] = '{
    '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
      17'd90},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
      17'd800, 17'd900},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
      17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
      17'd60000, 17'd70000, 17'd80000, 17'd90000}
  };

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_HEX  = 2'd1,
    CMD_DEC  = 2'd2
  } mpf_kind_t;

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [15:0] value;
  } mpf_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } mpf_out_t;

  typedef struct packed {
    mpf_kind_t   kind;
    logic [15:0] arg;
  } mpf_cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return CH_UPPER_A + {4'd0, d} - 8'd10;
  endfunction

endpackage

>>> src/mini_printf_formatter.sv
`timescale 1ns / 1ps

// channel   ports                            accepted when
// input     in_push, in_full, in_item        in_push && !in_full
// result    out_pop, out_empty, out_item     out_pop && !out_empty
//
// results stream at one character per cycle unless the result stalls or no
// command waits; the back end sequencer gives one character for an echo or
// character, four for hex, five for decimal. an item's first character passes
// the command queue and output register; items that give no character skip both.
// rst_n is synchronous and clears the pending flag, command queue and sequencer.
// a stalled result holds; input stalls only while the command queue is full.

module mini_printf_formatter
  import mpf_pkg::*;
#(
  parameter int CmdDepth = MPF_CMD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  mpf_in_t  in_item,
  output logic     out_empty,
  input  logic     out_pop,
  output mpf_out_t out_item
);

  logic     cmd_full;
  logic     cmd_push;
  mpf_cmd_t cmd_wr;
  logic     cmd_vld;
  logic     cmd_pop;
  mpf_cmd_t cmd_rd;

  mpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_wr)
  );

  mpf_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .vld     (cmd_vld),
    .rd_data (cmd_rd)
  );

  mpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (cmd_vld),
    .cmd       (cmd_rd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

>>> src/mpf_front.sv
`timescale 1ns / 1ps

module mpf_front
  import mpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  mpf_in_t  in_item,
  input  logic     cmd_full,
  output logic     cmd_push,
  output mpf_cmd_t cmd
);

  logic pending_r;
  logic pending_nxt;
  logic accept;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    pending_nxt = pending_r;
    cmd_push    = 1'b0;
    cmd.kind    = CMD_CHAR;
    cmd.arg     = {8'd0, in_item.fmt_char};
    if (accept) begin
      priority if (in_item.fmt_char == CH_NUL) begin
        pending_nxt = 1'b0;
      end else if (pending_r) begin
        pending_nxt = 1'b0;
        priority if (in_item.fmt_char == CH_LOWER_X || in_item.fmt_char == CH_UPPER_X) begin
          cmd_push = 1'b1;
          cmd.kind = CMD_HEX;
          cmd.arg  = in_item.value;
        end else if (in_item.fmt_char == CH_LOWER_D || in_item.fmt_char == CH_LOWER_I) begin
          cmd_push = 1'b1;
          cmd.kind = CMD_DEC;
          cmd.arg  = in_item.value;
        end else if (in_item.fmt_char == CH_LOWER_C || in_item.fmt_char == CH_UPPER_C) begin
          cmd_push = 1'b1;
          cmd.kind = CMD_CHAR;
          cmd.arg  = {8'd0, in_item.value[7:0]};
        end else begin
          cmd_push = 1'b0;
        end
      end else if (in_item.fmt_char == CH_PERCENT) begin
        pending_nxt = 1'b1;
      end else begin
        cmd_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

endmodule

>>> src/mpf_cmd_fifo.sv
`timescale 1ns / 1ps

module mpf_cmd_fifo
  import mpf_pkg::*;
#(
  parameter int Depth = MPF_CMD_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mpf_cmd_t wr_data,
  output logic     full,
  input  logic     pop,
  output logic     vld,
  output mpf_cmd_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mpf_cmd_t        mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign vld     = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("command queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !vld))
    else $error("command popped from empty queue");

endmodule

>>> src/mpf_back.sv
`timescale 1ns / 1ps

module mpf_back
  import mpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_vld,
  input  mpf_cmd_t cmd,
  output logic     cmd_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output mpf_out_t out_item
);

  logic        busy_r;
  mpf_kind_t   kind_r;
  logic [15:0] val_r;
  logic [2:0]  pos_r;
  logic        out_vld_r;
  mpf_out_t    out_r;

  mpf_kind_t   cur_kind;
  logic [15:0] cur_val;
  logic [2:0]  cur_pos;
  logic        cur_last;
  logic [3:0]  hex_nib;
  logic [3:0]  dec_dig;
  logic [16:0] dec_rem;
  logic [7:0]  cur_char;
  logic [15:0] val_nxt;
  logic        step;

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

  assign step    = (busy_r || cmd_vld) && (!out_vld_r || out_pop);
  assign cmd_pop = step && !busy_r;

  always_comb begin
    if (busy_r) begin
      cur_kind = kind_r;
      cur_val  = val_r;
      cur_pos  = pos_r;
    end else begin
      cur_kind = cmd.kind;
      cur_val  = cmd.arg;
      unique case (cmd.kind)
        CMD_HEX: cur_pos = POS_HEX_FIRST;
        CMD_DEC: cur_pos = POS_DEC_FIRST;
        default: cur_pos = POS_CHAR_FIRST;
      endcase
    end
  end

  assign cur_last = (cur_pos == 3'd0);

  always_comb begin
    unique case (cur_pos[1:0])
      2'd3: hex_nib = cur_val[15:12];
      2'd2: hex_nib = cur_val[11:8];
      2'd1: hex_nib = cur_val[7:4];
      2'd0: hex_nib = cur_val[3:0];
    endcase
  end

  // one decimal digit per step: compare against multiples of the place value
  always_comb begin
    dec_dig = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, cur_val} >= DEC_TBL[cur_pos][k]) begin
        dec_dig = 4'(k);
      end
    end
    dec_rem = {1'b0, cur_val} - DEC_TBL[cur_pos][dec_dig];
  end

  always_comb begin
    unique case (cur_kind)
      CMD_HEX: begin
        cur_char = digit_char(hex_nib);
        val_nxt  = cur_val;
      end
      CMD_DEC: begin
        cur_char = digit_char(dec_dig);
        val_nxt  = dec_rem[15:0];
      end
      default: begin
        cur_char = cur_val[7:0];
        val_nxt  = cur_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r.out_char <= cur_char;
      out_r.last     <= cur_last;
      kind_r         <= cur_kind;
      val_r          <= val_nxt;
      pos_r          <= cur_pos - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        busy_r    <= !cur_last;
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  a_busy_multi: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (kind_r == CMD_HEX || kind_r == CMD_DEC))
    else $error("sequencer busy on single character command");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r == CMD_HEX) |-> (pos_r < POS_HEX_FIRST))
    else $error("hex digit position out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cur_last) |=> !busy_r)
    else $error("sequencer still busy after last beat");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !cmd_pop)
    else $error("command taken while sequence in progress");

endmodule
